// ----- rtl/sql_token_splitter_core_defines.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the SQL token splitter
// ---------------------------------------------------------------------------
`ifndef SQL_TOKEN_SPLITTER_CORE_DEFINES_SVH
`define SQL_TOKEN_SPLITTER_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define SQLTS_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("sqlts: same-cycle check failed");

// Next-cycle implication, checked outside reset
`define SQLTS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("sqlts: next-cycle check failed");

`endif

// ----- rtl/sqlts_pkg.sv -----
// ---------------------------------------------------------------------------
// sqlts_pkg
// Types, character codes and byte classes shared by the token splitter.
// ---------------------------------------------------------------------------
package sqlts_pkg;

	localparam int LIMIT_W = 10;

	// Scanner modes
	typedef enum logic [3:0] {
		M_IDLE       = 4'd0,
		M_COLON      = 4'd1,
		M_DASH       = 4'd2,
		M_SLASH      = 4'd3,
		M_BLANK      = 4'd4,
		M_BIND       = 4'd5,
		M_QUOTE      = 4'd6,
		M_QUOTE_DONE = 4'd7,
		M_LINE       = 4'd8,
		M_LINE_DONE  = 4'd9,
		M_BLOCK      = 4'd10,
		M_BLOCK_DONE = 4'd11,
		M_IDENT      = 4'd12,
		M_NUMBER     = 4'd13,
		M_SINGLE     = 4'd14
	} mode_t;

	// Token kinds as seen on the output
	typedef enum logic [2:0] {
		K_BLANK  = 3'd0,
		K_BIND   = 3'd1,
		K_QUOTED = 3'd2,
		K_LINE   = 3'd3,
		K_BLOCK  = 3'd4,
		K_IDENT  = 3'd5,
		K_NUMBER = 3'd6,
		K_OTHER  = 3'd7
	} kind_t;

	// One output beat
	typedef struct packed {
		logic [7:0] out_byte;
		logic       keep;
		kind_t      token_kind;
		logic       token_end;
		logic       last;
	} result_t;

	// All beats caused by one input byte
	typedef struct packed {
		logic    two;
		result_t r0;
		result_t r1;
	} packet_t;

	// Character codes
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_NL     = 8'h0A;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_HASH   = 8'h23;
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_DASH   = 8'h2D;
	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_DIG_0  = 8'h30;
	localparam logic [7:0] CH_DIG_9  = 8'h39;
	localparam logic [7:0] CH_COLON  = 8'h3A;
	localparam logic [7:0] CH_UP_A   = 8'h41;
	localparam logic [7:0] CH_UP_E   = 8'h45;
	localparam logic [7:0] CH_UP_Z   = 8'h5A;
	localparam logic [7:0] CH_UNDER  = 8'h5F;
	localparam logic [7:0] CH_LOW_A  = 8'h61;
	localparam logic [7:0] CH_LOW_E  = 8'h65;
	localparam logic [7:0] CH_LOW_Z  = 8'h7A;

	function automatic logic is_letter(input logic [7:0] c);
		return (c >= CH_LOW_A && c <= CH_LOW_Z) || (c >= CH_UP_A && c <= CH_UP_Z);
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return c >= CH_DIG_0 && c <= CH_DIG_9;
	endfunction

	function automatic logic is_word(input logic [7:0] c);
		return is_letter(c) || is_digit(c) || c == CH_UNDER || c == CH_DOLLAR
			|| c == CH_HASH;
	endfunction

	function automatic logic is_numtail(input logic [7:0] c);
		return is_digit(c) || c == CH_DOT || c == CH_PLUS || c == CH_DASH
			|| c == CH_LOW_E || c == CH_UP_E;
	endfunction

	function automatic logic is_comment(input kind_t k);
		return k == K_LINE || k == K_BLOCK;
	endfunction

	// Mode entered by the first byte of a token
	function automatic mode_t start_mode(input logic [7:0] c);
		mode_t m;
		if (c == CH_SPACE || c == CH_TAB) m = M_BLANK;
		else if (c == CH_COLON || c == CH_DOLLAR) m = M_COLON;
		else if (c == CH_SQUOTE || c == CH_DQUOTE) m = M_QUOTE;
		else if (c == CH_DASH) m = M_DASH;
		else if (c == CH_SLASH) m = M_SLASH;
		else if (is_letter(c)) m = M_IDENT;
		else if (is_digit(c)) m = M_NUMBER;
		else m = M_SINGLE;
		return m;
	endfunction

	function automatic kind_t mode_kind(input mode_t m);
		kind_t k;
		unique case (m)
			M_BLANK:                   k = K_BLANK;
			M_BIND:                    k = K_BIND;
			M_QUOTE, M_QUOTE_DONE:     k = K_QUOTED;
			M_LINE, M_LINE_DONE:       k = K_LINE;
			M_BLOCK, M_BLOCK_DONE:     k = K_BLOCK;
			M_IDENT:                   k = K_IDENT;
			M_NUMBER:                  k = K_NUMBER;
			default:                   k = K_OTHER;
		endcase
		return k;
	endfunction

endpackage

// ----- rtl/sql_token_splitter_core.sv -----
// ---------------------------------------------------------------------------
// sql_token_splitter_core
// SQL text lexer: tags every byte with its token kind, keep and end marks.
// ---------------------------------------------------------------------------
// The block takes one text byte per cycle while s_axis_tready is high and
// releases each byte one input later, when the following byte shows
// whether its token goes on; the byte flagged end-of-text also releases
// itself, yielding two output beats when a byte is held. The output
// register sends one beat per cycle unless stalled, so the sustained rate
// is one byte per cycle, limited only by the output side for inputs that
// produce two beats. A queue of QUEUE_DEPTH packets between the scanner
// and the output register absorbs that difference and any downstream
// stall; s_axis_tready falls only when it is full. A beat passes through
// the queue, then the output register. The user must write token_limit
// through cfg_we/cfg_data only while no text is in flight (not enforced).
module sql_token_splitter_core #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [sqlts_pkg::LIMIT_W-1:0] cfg_data,      // token_limit
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	input  logic [7:0]                    s_axis_tdata,  // text_byte
	input  logic                          s_axis_tlast,  // end_of_text
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	output logic [7:0]                    m_axis_tdata,  // out_byte
	output logic [4:0]                    m_axis_tuser,  // keep, token_kind[2:0], token_end
	output logic                          m_axis_tlast   // last
);
	import sqlts_pkg::*;

	logic [LIMIT_W-1:0] token_limit_q;
	logic               q_full;
	logic               q_not_empty;
	logic               push;
	logic               pop;
	packet_t            wr_pkt;
	packet_t            rd_pkt;
	result_t            out_res;

	// Hold the length limit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) token_limit_q <= LIMIT_W'(255);
		else if (cfg_we) token_limit_q <= cfg_data;
	end

	sqlts_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (s_axis_tvalid),
		.in_ready    (s_axis_tready),
		.in_byte     (s_axis_tdata),
		.in_eot      (s_axis_tlast),
		.token_limit (token_limit_q),
		.q_full      (q_full),
		.push        (push),
		.pkt         (wr_pkt)
	);

	sqlts_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.wr_pkt    (wr_pkt),
		.full      (q_full),
		.pop       (pop),
		.not_empty (q_not_empty),
		.rd_pkt    (rd_pkt)
	);

	sqlts_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_not_empty (q_not_empty),
		.q_pkt       (rd_pkt),
		.pop         (pop),
		.out_valid   (m_axis_tvalid),
		.out_ready   (m_axis_tready),
		.out_res     (out_res)
	);

	// Pack the output beat
	assign m_axis_tdata = out_res.out_byte;
	assign m_axis_tuser = {out_res.token_end, out_res.token_kind, out_res.keep};
	assign m_axis_tlast = out_res.last;

endmodule

// ----- rtl/sqlts_front.sv -----
// ---------------------------------------------------------------------------
// sqlts_front
// Accepts text bytes, runs the one-byte-lookahead scanner and builds the
// packet of beats that each byte releases.
// ---------------------------------------------------------------------------
module sqlts_front (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [7:0]                  in_byte,
	input  logic                        in_eot,
	input  logic [sqlts_pkg::LIMIT_W-1:0] token_limit,
	input  logic                        q_full,
	output logic                        push,
	output sqlts_pkg::packet_t          pkt
);
	import sqlts_pkg::*;

	mode_t              mode_q;
	logic [7:0]         held_byte_q;
	logic               held_valid_q;
	logic [7:0]         quote_q;
	logic               saw_star_q;
	logic [LIMIT_W-1:0] kept_q;

	logic               accept;
	kind_t              kind1;
	kind_t              kind2;
	logic               cont;
	mode_t              next_cont;
	mode_t              mode_n;
	logic [7:0]         quote_n;
	logic               star_n;
	logic               keep1;
	logic               keep2;
	logic [LIMIT_W-1:0] kept1;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;

	// Decide whether the held byte's token goes on, and the next mode
	always_comb begin
		kind1     = mode_kind(mode_q);
		cont      = 1'b0;
		next_cont = M_IDLE;
		star_n    = saw_star_q;
		quote_n   = quote_q;
		unique case (mode_q)
			M_COLON: begin
				if (is_letter(in_byte)) begin
					kind1 = K_BIND; cont = 1'b1; next_cont = M_BIND;
				end
			end
			M_DASH: begin
				if (in_byte == CH_DASH) begin
					kind1 = K_LINE; cont = 1'b1; next_cont = M_LINE;
				end
			end
			M_SLASH: begin
				if (in_byte == CH_STAR) begin
					kind1 = K_BLOCK; cont = 1'b1; next_cont = M_BLOCK; star_n = 1'b0;
				end
			end
			M_BLANK: begin
				if (in_byte == CH_SPACE || in_byte == CH_TAB) begin
					cont = 1'b1; next_cont = M_BLANK;
				end
			end
			M_BIND, M_IDENT: begin
				if (is_word(in_byte)) begin
					cont = 1'b1; next_cont = mode_q;
				end
			end
			M_NUMBER: begin
				if (is_numtail(in_byte)) begin
					cont = 1'b1; next_cont = M_NUMBER;
				end
			end
			M_QUOTE: begin
				cont      = 1'b1;
				next_cont = (in_byte == quote_q) ? M_QUOTE_DONE : M_QUOTE;
			end
			M_LINE: begin
				cont      = 1'b1;
				next_cont = (in_byte == CH_NL) ? M_LINE_DONE : M_LINE;
			end
			M_BLOCK: begin
				cont = 1'b1;
				if (saw_star_q && in_byte == CH_SLASH) begin
					next_cont = M_BLOCK_DONE; star_n = 1'b0;
				end else begin
					next_cont = M_BLOCK; star_n = (in_byte == CH_STAR);
				end
			end
			default: begin
			end
		endcase

		// Start a new token when nothing is held or the held token ended
		if (held_valid_q && cont) begin
			mode_n = next_cont;
		end else begin
			mode_n = start_mode(in_byte);
			star_n = 1'b0;
			if (in_byte == CH_SQUOTE || in_byte == CH_DQUOTE) quote_n = in_byte;
		end
	end

	// Keep marks and kept-byte count across the one or two beats
	always_comb begin
		keep1 = held_valid_q && !is_comment(kind1) && (kept_q < token_limit);
		if (!held_valid_q) kept1 = kept_q;
		else if (!cont) kept1 = '0;
		else if (keep1) kept1 = kept_q + LIMIT_W'(1);
		else kept1 = kept_q;
		kind2 = mode_kind(mode_n);
		keep2 = !is_comment(kind2) && (kept1 < token_limit);
	end

	// Build the packet
	always_comb begin
		pkt.two           = held_valid_q && in_eot;
		pkt.r1.out_byte   = in_byte;
		pkt.r1.keep       = keep2;
		pkt.r1.token_kind = kind2;
		pkt.r1.token_end  = 1'b1;
		pkt.r1.last       = 1'b1;
		if (held_valid_q) begin
			pkt.r0.out_byte   = held_byte_q;
			pkt.r0.keep       = keep1;
			pkt.r0.token_kind = kind1;
			pkt.r0.token_end  = !cont;
			pkt.r0.last       = !in_eot;
		end else begin
			pkt.r0 = pkt.r1;
		end
	end

	assign push = accept && (held_valid_q || in_eot);

	// Advance scanner state on each accepted beat; end of text closes all
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= M_IDLE;
			held_byte_q  <= '0;
			held_valid_q <= 1'b0;
			quote_q      <= '0;
			saw_star_q   <= 1'b0;
			kept_q       <= '0;
		end else if (accept) begin
			if (in_eot) begin
				mode_q       <= M_IDLE;
				held_byte_q  <= '0;
				held_valid_q <= 1'b0;
				quote_q      <= '0;
				saw_star_q   <= 1'b0;
				kept_q       <= '0;
			end else begin
				mode_q       <= mode_n;
				held_byte_q  <= in_byte;
				held_valid_q <= 1'b1;
				quote_q      <= quote_n;
				saw_star_q   <= star_n;
				kept_q       <= kept1;
			end
		end
	end

endmodule

// ----- rtl/sqlts_queue.sv -----
// ---------------------------------------------------------------------------
// sqlts_queue
// Short packet queue between the scanner and the output serializer.
// ---------------------------------------------------------------------------
module sqlts_queue #(
	parameter int DEPTH = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  sqlts_pkg::packet_t wr_pkt,
	output logic               full,
	input  logic               pop,
	output logic               not_empty,
	output sqlts_pkg::packet_t rd_pkt
);
	import sqlts_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	packet_t            mem_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;

	assign full      = (count_q == CNT_W'(DEPTH));
	assign not_empty = (count_q != '0);
	assign rd_pkt    = mem_q[rd_ptr_q];

	// Hold written packets
	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= wr_pkt;
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) count_q <= count_q + CNT_W'(1);
			else if (pop && !push) count_q <= count_q - CNT_W'(1);
		end
	end

endmodule

// ----- rtl/sqlts_back.sv -----
// ---------------------------------------------------------------------------
// sqlts_back
// Pops packets and sends their beats one at a time from an output register.
// ---------------------------------------------------------------------------
module sqlts_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_not_empty,
	input  sqlts_pkg::packet_t q_pkt,
	output logic               pop,
	output logic               out_valid,
	input  logic               out_ready,
	output sqlts_pkg::result_t out_res
);
	import sqlts_pkg::*;

	logic    out_valid_q;
	result_t out_q;
	logic    pend_valid_q;
	result_t pend_q;
	logic    take;

	assign take      = !out_valid_q || out_ready;
	assign pop       = take && !pend_valid_q && q_not_empty;
	assign out_valid = out_valid_q;
	assign out_res   = out_q;

	// Load the output register: pending second beat first, then the queue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			pend_valid_q <= 1'b0;
		end else if (take) begin
			if (pend_valid_q) begin
				out_valid_q  <= 1'b1;
				pend_valid_q <= 1'b0;
			end else begin
				out_valid_q  <= q_not_empty;
				pend_valid_q <= q_not_empty && q_pkt.two;
			end
		end
	end

	// Payload of the output and pending registers
	always_ff @(posedge clk) begin
		if (take) begin
			if (pend_valid_q) begin
				out_q <= pend_q;
			end else if (q_not_empty) begin
				out_q  <= q_pkt.r0;
				pend_q <= q_pkt.r1;
			end
		end
	end

endmodule

// ----- rtl/sqlts_checker.sv -----
// ---------------------------------------------------------------------------
// sqlts_checker
// Port-level checks on the token splitter output stream.
// ---------------------------------------------------------------------------
`include "sql_token_splitter_core_defines.svh"

module sqlts_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       m_axis_tvalid,
	input logic       m_axis_tready,
	input logic [7:0] m_axis_tdata,
	input logic [4:0] m_axis_tuser,
	input logic       m_axis_tlast
);
	import sqlts_pkg::*;

	logic is_cmt;

	assign is_cmt = (m_axis_tuser[3:1] == K_LINE) || (m_axis_tuser[3:1] == K_BLOCK);

	// Stalled beat holds
	`SQLTS_ASSERT_NEXT(a_stall_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))

	// Comment bytes are never kept
	`SQLTS_ASSERT_IMPLY(a_cmt_not_kept, clk, arst_n, m_axis_tvalid && is_cmt, !m_axis_tuser[0])

	// The second beat of an input follows its first without a gap
	`SQLTS_ASSERT_NEXT(a_pair_back_to_back, clk, arst_n, m_axis_tvalid && m_axis_tready && !m_axis_tlast, m_axis_tvalid)

endmodule

bind sql_token_splitter_core sqlts_checker u_sqlts_checker (.*);
